@@ src/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion macros used by the checker file (ctd_checker).
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled while reset is asserted.
`define CTD_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// Clocked assertion that also holds during reset.
`define CTD_ASSERT_RST(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) prop) else $error(msg);

`endif

@@ src/ctd_pkg.sv @@
// ----------------------------------------------------------------------------
// ctd_pkg
// Types, codes and helpers for the chunked transfer decoder.
// ----------------------------------------------------------------------------
package ctd_pkg;

    localparam logic [7:0] CH_CR   = 8'h0D;
    localparam logic [7:0] CH_LF   = 8'h0A;
    localparam logic [7:0] CH_SEMI = 8'h3B;

    typedef enum logic [3:0] {
        PH_HDR_START  = 4'd0,
        PH_HDR_DIGITS = 4'd1,
        PH_EXT        = 4'd2,
        PH_HDR_LF     = 4'd3,
        PH_DATA       = 4'd4,
        PH_DATA_CR    = 4'd5,
        PH_DATA_LF    = 4'd6,
        PH_DONE       = 4'd7,
        PH_BAD        = 4'd8
    } phase_t;

    typedef enum logic [1:0] {
        KIND_DATA = 2'd0,
        KIND_END  = 2'd1,
        KIND_BAD  = 2'd2
    } kind_t;

    typedef struct packed {
        logic [7:0] byte_value;
        logic       end_of_stream;
    } item_t;

    typedef struct packed {
        logic       valid;
        logic [7:0] payload_byte;
        kind_t      kind;
    } result_t;

    typedef struct packed {
        logic       ok;
        logic [3:0] val;
    } hex_t;

    function automatic hex_t hex_digit(input logic [7:0] c);
        hex_t       h;
        logic [7:0] d;
        h.ok  = 1'b1;
        d     = 8'h00;
        if (c inside {[8'h30:8'h39]}) begin
            d = c - 8'h30;
        end else if (c inside {[8'h61:8'h66]}) begin
            d = c - 8'h57;
        end else if (c inside {[8'h41:8'h46]}) begin
            d = c - 8'h37;
        end else begin
            h.ok = 1'b0;
        end
        h.val = d[3:0];
        return h;
    endfunction

endpackage

@@ src/ctd_input_stage.sv @@
// ----------------------------------------------------------------------------
// ctd_input_stage
// Input register: holds one transfer until the parser consumes it.
// ----------------------------------------------------------------------------
module ctd_input_stage (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_tvalid,
    output logic           s_tready,
    input  logic [7:0]     s_tdata,   // [7:0] byte_value
    input  logic           s_tlast,   // end_of_stream
    input  logic           take,
    output logic           item_valid,
    output ctd_pkg::item_t item
);

    logic           valid_reg;
    ctd_pkg::item_t item_reg;

    assign s_tready   = !valid_reg || take;
    assign item_valid = valid_reg;
    assign item       = item_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (s_tready) begin
            valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            item_reg.byte_value    <= s_tdata;
            item_reg.end_of_stream <= s_tlast;
        end
    end

endmodule

@@ src/ctd_parser.sv @@
// ----------------------------------------------------------------------------
// ctd_parser
// Framing state machine: hex length, extension skip, CRLF checks, data count.
// ----------------------------------------------------------------------------
module ctd_parser #(
    parameter int LEN_BITS   = 32,
    parameter int MAX_DIGITS = 8
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             advance,
    input  ctd_pkg::item_t   item,
    output ctd_pkg::result_t res
);

    localparam int CNT_W = $clog2(MAX_DIGITS + 1);

    ctd_pkg::phase_t     phase_reg, phase_next;
    logic [LEN_BITS-1:0] left_reg, left_next;
    logic [CNT_W-1:0]    count_reg, count_next;

    ctd_pkg::hex_t       hex;
    logic [LEN_BITS-1:0] left_dec;
    logic                digit_ok;

    assign hex      = ctd_pkg::hex_digit(item.byte_value);
    assign left_dec = left_reg - LEN_BITS'(1);
    assign digit_ok = (count_reg < CNT_W'(MAX_DIGITS)) &&
                      (left_reg[LEN_BITS-1 -: 4] == 4'h0);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= ctd_pkg::PH_HDR_START;
            left_reg  <= '0;
            count_reg <= '0;
        end else if (advance) begin
            phase_reg <= phase_next;
            left_reg  <= left_next;
            count_reg <= count_next;
        end
    end

    always_comb begin
        phase_next       = phase_reg;
        left_next        = left_reg;
        count_next       = count_reg;
        res.valid        = 1'b0;
        res.payload_byte = 8'h00;
        res.kind         = ctd_pkg::KIND_BAD;
        if (phase_reg != ctd_pkg::PH_DONE && phase_reg != ctd_pkg::PH_BAD &&
            item.end_of_stream) begin
            phase_next = ctd_pkg::PH_BAD;
            res.valid  = 1'b1;
        end else begin
            case (phase_reg)
                ctd_pkg::PH_HDR_START, ctd_pkg::PH_HDR_DIGITS: begin
                    if (hex.ok) begin
                        if (digit_ok) begin
                            left_next  = {left_reg[LEN_BITS-5:0], hex.val};
                            count_next = count_reg + CNT_W'(1);
                            phase_next = ctd_pkg::PH_HDR_DIGITS;
                        end else begin
                            phase_next = ctd_pkg::PH_BAD;
                            res.valid  = 1'b1;
                        end
                    end else if (phase_reg == ctd_pkg::PH_HDR_DIGITS &&
                                 item.byte_value == ctd_pkg::CH_SEMI) begin
                        phase_next = ctd_pkg::PH_EXT;
                    end else if (phase_reg == ctd_pkg::PH_HDR_DIGITS &&
                                 item.byte_value == ctd_pkg::CH_CR) begin
                        phase_next = ctd_pkg::PH_HDR_LF;
                    end else begin
                        phase_next = ctd_pkg::PH_BAD;
                        res.valid  = 1'b1;
                    end
                end
                ctd_pkg::PH_EXT: begin
                    if (item.byte_value == ctd_pkg::CH_CR) begin
                        phase_next = ctd_pkg::PH_HDR_LF;
                    end
                end
                ctd_pkg::PH_HDR_LF: begin
                    if (item.byte_value != ctd_pkg::CH_LF) begin
                        phase_next = ctd_pkg::PH_BAD;
                        res.valid  = 1'b1;
                    end else begin
                        count_next = '0;
                        if (left_reg == '0) begin
                            phase_next = ctd_pkg::PH_DONE;
                            res.valid  = 1'b1;
                            res.kind   = ctd_pkg::KIND_END;
                        end else begin
                            phase_next = ctd_pkg::PH_DATA;
                        end
                    end
                end
                ctd_pkg::PH_DATA: begin
                    left_next        = left_dec;
                    res.valid        = 1'b1;
                    res.kind         = ctd_pkg::KIND_DATA;
                    res.payload_byte = item.byte_value;
                    if (left_dec == '0) begin
                        phase_next = ctd_pkg::PH_DATA_CR;
                    end
                end
                ctd_pkg::PH_DATA_CR: begin
                    if (item.byte_value != ctd_pkg::CH_CR) begin
                        phase_next = ctd_pkg::PH_BAD;
                        res.valid  = 1'b1;
                    end else begin
                        phase_next = ctd_pkg::PH_DATA_LF;
                    end
                end
                ctd_pkg::PH_DATA_LF: begin
                    if (item.byte_value != ctd_pkg::CH_LF) begin
                        phase_next = ctd_pkg::PH_BAD;
                        res.valid  = 1'b1;
                    end else begin
                        phase_next = ctd_pkg::PH_HDR_START;
                        left_next  = '0;
                        count_next = '0;
                    end
                end
                default: begin
                    // body finished or failed: silent
                end
            endcase
        end
        // a result exists only for an item that is consumed this cycle
        if (!advance) begin
            res.valid = 1'b0;
        end
    end

endmodule

@@ src/ctd_output_stage.sv @@
// ----------------------------------------------------------------------------
// ctd_output_stage
// Result register on the master side.
// ----------------------------------------------------------------------------
module ctd_output_stage (
    input  logic             aclk,
    input  logic             aresetn,
    input  ctd_pkg::result_t res,
    output logic             can_load,
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [7:0]       m_tdata,   // [7:0] payload_byte
    output logic [1:0]       m_tuser    // [1:0] kind
);

    logic       valid_reg;
    logic [7:0] data_reg;
    logic [1:0] kind_reg;

    assign can_load = !valid_reg || m_tready;
    assign m_tvalid = valid_reg;
    assign m_tdata  = data_reg;
    assign m_tuser  = kind_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (res.valid) begin
            valid_reg <= 1'b1;
        end else if (m_tready) begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (res.valid) begin
            data_reg <= res.payload_byte;
            kind_reg <= res.kind;
        end
    end

endmodule

@@ src/chunked_transfer_decoder.sv @@
// ----------------------------------------------------------------------------
// chunked_transfer_decoder
// Strips HTTP chunked framing from a byte stream, one byte per transfer.
// ----------------------------------------------------------------------------
//  channel  dir  tdata              tuser      tlast
//  s_       in   [7:0] byte_value   -          end_of_stream
//  m_       out  [7:0] payload_byte [1:0] kind -
//
// One transfer per cycle sustained while m_tready stays high; from s_ to m_ a byte
// passes the input register, then the parser step into the result register.
// Reset: synchronous, aresetn low; parser returns to the first chunk header.
// A stalled m_ side holds the result; s_tready drops only when both the
// input register and the result register are full.
// ----------------------------------------------------------------------------
module chunked_transfer_decoder #(
    parameter int LEN_BITS   = 32,
    parameter int MAX_DIGITS = 8
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] byte_value
    input  logic       s_tlast,   // end_of_stream
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [7:0] payload_byte
    output logic [1:0] m_tuser    // [1:0] kind
);

    ctd_pkg::item_t   item;
    ctd_pkg::result_t res;
    logic             item_valid;
    logic             can_load;
    logic             advance;

    assign advance = item_valid && can_load;

    ctd_input_stage u_in (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tlast    (s_tlast),
        .take       (advance),
        .item_valid (item_valid),
        .item       (item)
    );

    ctd_parser #(
        .LEN_BITS   (LEN_BITS),
        .MAX_DIGITS (MAX_DIGITS)
    ) u_parser (
        .aclk    (aclk),
        .aresetn (aresetn),
        .advance (advance),
        .item    (item),
        .res     (res)
    );

    ctd_output_stage u_out (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .res      (res),
        .can_load (can_load),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

endmodule

@@ src/ctd_checker.sv @@
// ----------------------------------------------------------------------------
// ctd_checker
// Port-level checks for the chunked transfer decoder.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ctd_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       m_tvalid,
    input logic       m_tready,
    input logic [7:0] m_tdata,
    input logic [1:0] m_tuser
);

    logic       terminal;
    logic       stalled;
    logic [9:0] m_out;

    assign terminal = (m_tuser == ctd_pkg::KIND_END) || (m_tuser == ctd_pkg::KIND_BAD);
    assign stalled  = m_tvalid && !m_tready;
    assign m_out    = {m_tuser, m_tdata};

    `CTD_ASSERT_RST(a_reset_empty, !aresetn |=> !m_tvalid, "result valid after reset")

    `CTD_ASSERT(a_hold, stalled |=> m_tvalid && $stable(m_out), "stalled result changed")

    `CTD_ASSERT(a_kind_code, m_tvalid |-> terminal || m_tuser == ctd_pkg::KIND_DATA, "bad kind")

    `CTD_ASSERT(a_status_zero, m_tvalid && terminal |-> m_tdata == 8'h00, "status carries data")

    `CTD_ASSERT(a_silent_after_end, m_tvalid && m_tready && terminal |=> !m_tvalid, "late result")

endmodule

bind chunked_transfer_decoder ctd_checker u_ctd_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
